@@ design/ctcc_pkg.sv @@
// shared types and constants for the caption trigger checksum checker
// no dependencies
package ctcc_pkg;

  localparam int BufferBytesDefault = 256;
  localparam int MidDepth = 2;
  localparam int OutDepth = 2;

  localparam logic [15:0] CharMask  = 16'h7F7F;
  localparam logic [15:0] PairMask  = 16'h6000;
  localparam logic [15:0] ChanBit   = 16'h0800;
  localparam logic [15:0] CrCode    = 16'h142D;

  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindPair  = 2'd1;
  localparam logic [1:0] KindCr    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] hi;
    logic [6:0] lo;
  } front_item_t;

  typedef struct packed {
    logic line_valid;
    logic line_ended;
  } result_t;

endpackage

@@ design/ctcc_queue.sv @@
// small show-ahead queue of registers
// depends on nothing beyond its parameters
module ctcc_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_full,
  output logic             q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/ctcc_front.sv @@
// front end: masks caption words and sorts them into pair, carriage return or other
// depends on ctcc_pkg
module ctcc_front import ctcc_pkg::*; (
  input  logic        push,
  input  logic [15:0] caption_word,
  output logic        q_push,
  output front_item_t q_item
);

  logic [15:0] w;

  assign w      = caption_word & CharMask;
  assign q_push = push;

  always_comb begin
    q_item.hi = w[14:8];
    q_item.lo = w[6:0];
    if ((w & PairMask) != '0) begin
      q_item.kind = KindPair;
    end else if ((w & ~ChanBit) == CrCode) begin
      q_item.kind = KindCr;
    end else begin
      q_item.kind = KindOther;
    end
  end

endmodule

@@ design/ctcc_back.sv @@
// back end: line state, ones-complement sum, bracket and hex tracking, line verdict
// depends on ctcc_pkg
module ctcc_back import ctcc_pkg::*; #(
  parameter int BUFFER_BYTES = BufferBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  front_item_t item,
  input  logic        item_avail,
  input  logic        out_full,
  output logic        item_take,
  output logic        res_push,
  output result_t     res
);

  localparam int BW = $clog2(BUFFER_BYTES) + 1;
  localparam logic [6:0] OpenBracket  = 7'h5B;
  localparam logic [6:0] CloseBracket = 7'h5D;

  typedef struct packed {
    logic        open_seen;
    logic [15:0] sum_at_open;
    logic [15:0] hex_value;
    logic        hex_active;
    logic        hex_ovf;
    logic        cm_present;
    logic [15:0] cm_sum;
    logic [15:0] cm_hex;
    logic        cm_ovf;
  } line_t;

  logic [BW-1:0] byte_count;
  logic [BW-1:0] byte_count_next;
  logic [15:0]   running_sum;
  logic [15:0]   running_sum_next;
  line_t         ls;
  line_t         ls_next;
  logic [15:0]   sum_mid;
  line_t         ls_mid;
  logic          room;

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [4:0] hex_digit(logic [6:0] b);
    logic [6:0] d;
    d = '0;
    if (b inside {[7'h30:7'h39]}) begin
      d = b - 7'h30;
      return {1'b1, d[3:0]};
    end else if (b inside {[7'h41:7'h46]}) begin
      d = b - 7'h37;
      return {1'b1, d[3:0]};
    end else if (b inside {[7'h61:7'h66]}) begin
      d = b - 7'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic line_t take_byte(line_t s, logic [15:0] sum, logic [6:0] b);
    line_t r;
    logic [4:0] d;
    r = s;
    d = hex_digit(b);
    if (b == CloseBracket) begin
      if (s.open_seen) begin
        r.cm_present = 1'b1;
        r.cm_sum     = s.sum_at_open;
        r.cm_hex     = s.hex_value;
        r.cm_ovf     = s.hex_ovf;
      end
      r.hex_active = 1'b0;
    end else if (b == OpenBracket) begin
      r.open_seen   = 1'b1;
      r.sum_at_open = sum;
      r.hex_value   = '0;
      r.hex_active  = 1'b1;
      r.hex_ovf     = 1'b0;
    end else if (s.hex_active) begin
      if (!d[4]) begin
        r.hex_active = 1'b0;
      end else begin
        if (s.hex_value[15:12] != 4'd0) begin
          r.hex_ovf = 1'b1;
        end
        r.hex_value = {s.hex_value[11:0], d[3:0]};
      end
    end
    return r;
  endfunction

  assign item_take = item_avail && !out_full;
  assign res_push  = item_take;
  assign room      = ({1'b0, byte_count} + (BW + 1)'(2)) < (BW + 1)'(BUFFER_BYTES);
  assign ls_mid    = take_byte(ls, running_sum, item.hi);
  assign sum_mid   = oc_add(running_sum, {1'b0, item.hi, 8'd0});

  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    ls_next          = ls;
    res.line_valid   = 1'b0;
    res.line_ended   = 1'b0;
    case (item.kind)
      KindPair: begin
        if (room) begin
          ls_next          = take_byte(ls_mid, sum_mid, item.lo);
          running_sum_next = oc_add(sum_mid, {9'd0, item.lo});
          byte_count_next  = byte_count + BW'(2);
        end
      end
      KindCr: begin
        res.line_ended = 1'b1;
        if (byte_count != '0) begin
          res.line_valid   = ls.cm_present && !ls.cm_ovf && ((ls.cm_sum ^ 16'hFFFF) == ls.cm_hex);
          byte_count_next  = '0;
          running_sum_next = '0;
          ls_next          = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      ls          <= '0;
    end else if (item_take) begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      ls          <= ls_next;
    end
  end

endmodule

@@ design/caption_trigger_checksum_checker_unit.sv @@
// caption trigger checksum checker, top level: front end, item queue, back end, result queue
// a result is pushed into the result queue when its item is accepted
// throughput: one item per cycle while the result queue has room; both bytes are summed at once
// reset: synchronous rst empties both queues and clears the line state
// depends on ctcc_pkg, ctcc_front, ctcc_queue, ctcc_back
module caption_trigger_checksum_checker_unit import ctcc_pkg::*; #(
  parameter int BUFFER_BYTES = BufferBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] caption_word,
  output logic        empty,
  input  logic        pop,
  output logic        line_valid,
  output logic        line_ended
);

  logic        f_push;
  front_item_t f_item;
  front_item_t m_item;
  logic        m_empty;
  logic        m_take;
  logic        o_full;
  logic        r_push;
  result_t     r_data;
  result_t     o_data;

  ctcc_front u_front (
    .push         (push),
    .caption_word (caption_word),
    .q_push       (f_push),
    .q_item       (f_item)
  );

  ctcc_queue #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (MidDepth)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_item),
    .rd_en   (m_take),
    .rd_data (m_item),
    .q_full  (full),
    .q_empty (m_empty)
  );

  ctcc_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (m_item),
    .item_avail (!m_empty),
    .out_full   (o_full),
    .item_take  (m_take),
    .res_push   (r_push),
    .res        (r_data)
  );

  ctcc_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OutDepth)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (r_push),
    .wr_data (r_data),
    .rd_en   (pop),
    .rd_data (o_data),
    .q_full  (o_full),
    .q_empty (empty)
  );

  assign line_valid = o_data.line_valid;
  assign line_ended = o_data.line_ended;

endmodule
